// ===== rtl/core/mxt_pkg.sv =====
package mxt_pkg;

   localparam int KEY_W = 32;
   localparam int DEF_POOL_NODES = 4096;
   localparam int DEF_KEY_BITS = 32;

   typedef struct packed {
      logic [KEY_W-1:0] key_value;
      logic             last_item;
   } req_type;

   typedef struct packed {
      logic [KEY_W-1:0] best_xor;
      logic             pool_full;
   } rsp_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_QUERY,
      S_INSERT,
      S_DONE
   } state_type;

endpackage

// ===== rtl/core/max_xor_pair_bit_trie_top.sv =====
// Maximum XOR pair engine over a binary trie of unsigned keys.
// Input channel req_*: one key per transfer; last_item closes the current set.
// Result channel rsp_*: one result per key, the largest XOR of any two keys of
// the set so far and a flag that the node pool ran out before this key was stored.
// Each key is handled alone: a query walk of up to KEY_BITS levels (skipped for
// the first key of a set, shorter on a dead end), an insert walk of up to
// KEY_BITS levels (skipped once the pool is full), and a load of the result
// register. Both walks advance one trie level per cycle, bounded by the
// single read port of the link memory (registered read).
// The root's two links live in flip-flops; pool nodes live in the memory and
// read as empty while freshly allocated, so the memory needs no clearing pass.
// Reset (synchronous, active high) empties the trie, the running maximum and
// the full flag; after a last_item key the same state is cleared.
// A result waits in the output register while rsp_ready is low; the next key
// is still taken and worked on, and holds in its final cycle until the output
// register frees up.
module max_xor_pair_bit_trie_top
   import mxt_pkg::*;
#(
   parameter int POOL_NODES = DEF_POOL_NODES,
   parameter int KEY_BITS   = DEF_KEY_BITS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int LINK_W = $clog2(POOL_NODES);
   localparam int CNT_W  = $clog2(POOL_NODES + 1);
   localparam int LVL_W  = $clog2(KEY_BITS);

   typedef logic [1:0][LINK_W-1:0] links_type;

   links_type mem [POOL_NODES];
   links_type mem_q;
   logic              mem_we;
   logic [LINK_W-1:0] mem_wa;
   links_type         mem_wd;
   logic [LINK_W-1:0] rd_addr;

   state_type state_ff, state_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic                last_ff, last_in;
   logic [LVL_W-1:0]    lvl_ff, lvl_in;
   logic [LINK_W-1:0]   node_ff, node_in;
   logic                fresh_ff, fresh_in;
   logic [KEY_BITS-1:0] acc_ff, acc_in;
   logic [KEY_BITS-1:0] best_ff, best_in;
   logic                has_key_ff, has_key_in;
   logic                full_ff, full_in;
   logic                full_now_ff, full_now_in;
   logic [CNT_W-1:0]    used_ff, used_in;
   links_type           root_ff, root_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   links_type           cur_links;
   logic [6:0]          lvl_wide;
   logic                key_bit;
   logic [LINK_W-1:0]   q_want, q_same, ins_nxt;
   logic                lvl_zero, q_end, pool_out, ins_end, rsp_free;
   logic [KEY_BITS-1:0] lvl_mask, acc_nx;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      mem_q <= mem[rd_addr];
   end

   // current node's links: root from flip-flops, fresh node known empty
   always_comb begin
      if (fresh_ff) begin
         cur_links = '0;
      end else if (node_ff == '0) begin
         cur_links = root_ff;
      end else begin
         cur_links = mem_q;
      end
      lvl_wide = 7'(lvl_ff);
      key_bit  = (lvl_wide < 7'd32) ? key_ff[lvl_wide[4:0]] : 1'b0;
      q_want   = cur_links[~key_bit];
      q_same   = cur_links[key_bit];
      ins_nxt  = q_same;
      lvl_zero = (lvl_ff == '0);
      q_end    = ((q_want == '0) && (q_same == '0)) || lvl_zero;
      pool_out = (used_ff == CNT_W'(POOL_NODES));
      ins_end  = ((ins_nxt == '0) && pool_out) || lvl_zero;
      rsp_free = !rsp_valid_ff || rsp_ready;
      lvl_mask = KEY_BITS'(1) << lvl_ff;
      acc_nx   = (q_want != '0) ? (acc_ff | lvl_mask) : acc_ff;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (has_key_ff) begin
                  state_in = S_QUERY;
               end else if (full_ff) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_INSERT;
               end
            end
         end
         S_QUERY: begin
            if (q_end) begin
               state_in = full_ff ? S_DONE : S_INSERT;
            end
         end
         S_INSERT: begin
            if (ins_end) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      key_in       = key_ff;
      last_in      = last_ff;
      lvl_in       = lvl_ff;
      node_in      = node_ff;
      fresh_in     = fresh_ff;
      acc_in       = acc_ff;
      best_in      = best_ff;
      has_key_in   = has_key_ff;
      full_in      = full_ff;
      full_now_in  = full_now_ff;
      used_in      = used_ff;
      root_in      = root_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_wa       = node_ff;
      mem_wd       = cur_links;
      rd_addr      = node_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               key_in      = req_data.key_value;
               last_in     = req_data.last_item;
               lvl_in      = LVL_W'(KEY_BITS - 1);
               node_in     = '0;
               fresh_in    = 1'b0;
               acc_in      = '0;
               full_now_in = full_ff;
            end
         end
         S_QUERY: begin
            lvl_in = lvl_ff - LVL_W'(1);
            acc_in = acc_nx;
            if (q_want != '0) begin
               node_in = q_want;
            end else begin
               node_in = q_same;
            end
            rd_addr = node_in;
            if (q_end) begin
               if (acc_nx > best_ff) begin
                  best_in = acc_nx;
               end
               lvl_in  = LVL_W'(KEY_BITS - 1);
               node_in = '0;
            end
         end
         S_INSERT: begin
            lvl_in = lvl_ff - LVL_W'(1);
            if (ins_nxt != '0) begin
               node_in  = ins_nxt;
               fresh_in = 1'b0;
               rd_addr  = ins_nxt;
            end else if (pool_out) begin
               // stop here; leave a freshly allocated node readable as empty
               full_in     = 1'b1;
               full_now_in = 1'b1;
               mem_we      = fresh_ff;
               mem_wd      = '0;
            end else begin
               node_in  = used_ff[LINK_W-1:0];
               fresh_in = 1'b1;
               used_in  = used_ff + CNT_W'(1);
               if (node_ff == '0) begin
                  root_in[key_bit] = used_ff[LINK_W-1:0];
               end else begin
                  mem_we                = 1'b1;
                  mem_wd[key_bit]       = used_ff[LINK_W-1:0];
               end
               rd_addr = used_ff[LINK_W-1:0];
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.best_xor    = KEY_W'(best_ff);
               rsp_in.pool_full   = full_now_ff;
               fresh_in           = 1'b0;
               node_in            = '0;
               if (last_ff) begin
                  root_in    = '0;
                  used_in    = CNT_W'(1);
                  best_in    = '0;
                  has_key_in = 1'b0;
                  full_in    = 1'b0;
               end else begin
                  has_key_in = 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         lvl_ff       <= '0;
         node_ff      <= '0;
         fresh_ff     <= 1'b0;
         best_ff      <= '0;
         has_key_ff   <= 1'b0;
         full_ff      <= 1'b0;
         full_now_ff  <= 1'b0;
         used_ff      <= CNT_W'(1);
         root_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lvl_ff       <= lvl_in;
         node_ff      <= node_in;
         fresh_ff     <= fresh_in;
         best_ff      <= best_in;
         has_key_ff   <= has_key_in;
         full_ff      <= full_in;
         full_now_ff  <= full_now_in;
         used_ff      <= used_in;
         root_ff      <= root_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      last_ff <= last_in;
      acc_ff  <= acc_in;
      rsp_ff  <= rsp_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   a_used_range: assert property (@(posedge clock) disable iff (reset)
      (used_ff >= CNT_W'(1)) && (used_ff <= CNT_W'(POOL_NODES)))
      else $error("node count out of range");

   a_fresh_not_root: assert property (@(posedge clock) disable iff (reset)
      fresh_ff |-> (node_ff != '0))
      else $error("root marked as fresh node");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (mem_we && (state_ff == S_INSERT) && (state_in == S_INSERT)) |-> (rd_addr != mem_wa))
      else $error("link read and write hit the same node");

   a_set_cleared: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_DONE) && rsp_free && last_ff)
      |=> ((used_ff == CNT_W'(1)) && !has_key_ff && !full_ff && (root_ff == '0)))
      else $error("set state not cleared after last item");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_DONE) && !rsp_free) |=> (state_ff == S_DONE) && rsp_valid_ff)
      else $error("result slot overrun");
`endif

endmodule
